@@ rtl/abkf_pkg.sv @@
// Shared types, codes and saturation helpers for the angle and bias Kalman filter.
// Used by abkf_mac and angle_bias_kalman_filter; depends on nothing else.
`timescale 1ns / 1ps

package abkf_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MLO,
    ST_MHI,
    ST_WB,
    ST_DSET,
    ST_DIV,
    ST_OUT
  } state_t;

  // Products of one update, in the order they are run.
  typedef enum logic [3:0] {
    OP_DRATE,
    OP_DC11,
    OP_DT,
    OP_DBN,
    OP_K0E,
    OP_K1E,
    OP_K1P00,
    OP_K1P01,
    OP_K0P01,
    OP_K0P00
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  // Multiply-accumulate unit widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 48;
  localparam int HALF_W  = 24;
  localparam int PROD_W  = MUL_A_W + HALF_W + 1;
  localparam int ACC_W   = 82;

  // Largest gain magnitude, signed Q.24.
  localparam logic [30:0] GAIN_MAX = 31'h7fffffff;

  // Control of the multiply-accumulate unit.
  typedef struct packed {
    logic load;
    logic hi_half;
  } mac_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [39:0] r;
    if (v > 64'sd549755813887) begin
      r = 40'sh7fffffffff;
    end else if (v < -64'sd549755813888) begin
      r = 40'sh8000000000;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/abkf_mac.sv @@
// Shared multiply-accumulate unit: a 34-bit signed operand times a 48-bit signed
// operand, formed from its two 24-bit halves in turn. Depends on abkf_pkg.
`timescale 1ns / 1ps

module abkf_mac (
  input  logic                                 clk,
  input  abkf_pkg::mac_ctl_t                   ctl,
  input  logic signed [abkf_pkg::MUL_A_W-1:0]  a,
  input  logic signed [abkf_pkg::MUL_B_W-1:0]  b,
  output logic signed [abkf_pkg::ACC_W-1:0]    acc
);

  logic signed [abkf_pkg::HALF_W:0]   b_part;
  logic signed [abkf_pkg::PROD_W-1:0] prod;
  logic signed [abkf_pkg::ACC_W-1:0]  prod_ext;

  // Low half is unsigned, high half carries the sign.
  always_comb begin
    if (ctl.hi_half) begin
      b_part = {b[abkf_pkg::MUL_B_W-1], b[abkf_pkg::MUL_B_W-1:abkf_pkg::HALF_W]};
    end else begin
      b_part = {1'b0, b[abkf_pkg::HALF_W-1:0]};
    end
    prod     = a * b_part;
    prod_ext = {{(abkf_pkg::ACC_W - abkf_pkg::PROD_W){prod[abkf_pkg::PROD_W-1]}}, prod};
  end

  // The low-half load sets the low partial product, the high-half load adds the high one.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.hi_half) begin
        acc <= acc + {prod_ext[abkf_pkg::ACC_W-abkf_pkg::HALF_W-1:0],
                      {abkf_pkg::HALF_W{1'b0}}};
      end else begin
        acc <= prod_ext;
      end
    end
  end

endmodule

@@ rtl/angle_bias_kalman_filter.sv @@
// Top level of the two-state angle and gyro bias Kalman filter.
// Depends on abkf_pkg and abkf_mac.
`timescale 1ns / 1ps

// Usage:
// One sample item enters on the s_ group: s_tuser is the mode (0 update,
// 1 seed the stored angle), s_tdata carries measured angle, gyro rate and
// step time. One result item leaves on the m_ group with the filtered angle,
// the bias-corrected rate and the bias estimate.
// The block works on one item at a time; s_tready is high only while idle.
// A seed item raises m_tvalid in the cycle after acceptance. An update item
// raises m_tvalid after ten products on the shared multiplier, each through
// ST_MLO, ST_MHI and ST_WB (low half, high half, write-back), and two gain
// divisions, each a ST_DSET setup plus 31 restoring steps on one shared
// subtractor. A gain that is zero or clamped skips its 31 steps.
// The result holds on m_tdata while m_tready is low; no new item is taken
// until it is delivered. Configuration writes (cfg_we, cfg_addr, cfg_data)
// take effect at once and are meant for idle periods.
// Synchronous reset clears the state estimates and covariance to zero and
// loads the default noise registers.

module angle_bias_kalman_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // measured_angle[31:0], gyro_rate[63:32], step_time[83:64]
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,  // filtered_angle[31:0], corrected_rate[63:32],
                                // bias_estimate[95:64]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [39:0] cfg_data
);

  abkf_pkg::state_t state, state_next;
  abkf_pkg::op_t    op;
  abkf_pkg::mac_ctl_t mac_ctl;

  logic               gsel;
  logic [4:0]         cnt;
  logic [39:0]        angle_noise, bias_noise, measure_noise;
  logic signed [31:0] angle, bias, meas, rate;
  logic [19:0]        dt;
  logic signed [39:0] c00, c01, c10, c11;
  logic signed [40:0] dp11;
  logic signed [32:0] err;
  logic signed [31:0] k0, k1;
  logic [40:0]        s_reg;
  logic [39:0]        mag;
  logic               neg;
  logic [40:0]        rem;
  logic [29:0]        quo;

  logic signed [abkf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [abkf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [abkf_pkg::ACC_W-1:0]   acc;
  logic signed [abkf_pkg::ACC_W-1:0]   acc_s20, acc_s24;
  logic signed [63:0]                  sh20, sh24;
  logic signed [47:0]                  t_val;

  logic signed [41:0] s_full;
  logic               s_pos;
  logic signed [39:0] p_sel;
  logic [39:0]        p_mag;
  logic               ovf;
  logic               dbit;
  logic [41:0]        rem2;
  logic               ge;
  logic [30:0]        q_fin;
  logic               div_done;

  // Shared multiply-accumulate unit.
  abkf_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mul_a),
    .b   (mul_b),
    .acc (acc)
  );

  // Operand selection for the current product.
  always_comb begin
    t_val = 48'(dp11) - 48'(c01) - 48'(c10) + {8'b0, angle_noise};
    unique case (op) inside
      abkf_pkg::OP_DRATE, abkf_pkg::OP_DC11, abkf_pkg::OP_DT, abkf_pkg::OP_DBN: begin
        mul_a = {14'b0, dt};
      end
      abkf_pkg::OP_K0E, abkf_pkg::OP_K0P01, abkf_pkg::OP_K0P00: begin
        mul_a = 34'(k0);
      end
      default: begin
        mul_a = 34'(k1);
      end
    endcase
    unique case (op) inside
      abkf_pkg::OP_DRATE: mul_b = 48'(rate) - 48'(bias);
      abkf_pkg::OP_DC11:  mul_b = 48'(c11);
      abkf_pkg::OP_DT:    mul_b = t_val;
      abkf_pkg::OP_DBN:   mul_b = {8'b0, bias_noise};
      abkf_pkg::OP_K0E, abkf_pkg::OP_K1E: mul_b = 48'(err);
      abkf_pkg::OP_K1P00, abkf_pkg::OP_K0P00: mul_b = 48'(c00);
      default:            mul_b = 48'(c01);
    endcase
  end

  // Scaled products and gain division helpers.
  always_comb begin
    acc_s20  = acc >>> 20;
    acc_s24  = acc >>> 24;
    sh20     = acc_s20[63:0];
    sh24     = acc_s24[63:0];
    s_full   = 42'(c00) + {2'b0, measure_noise};
    s_pos    = !s_full[41] && (s_full != 42'sd0);
    p_sel    = gsel ? c10 : c00;
    p_mag    = p_sel[39] ? 40'(-p_sel) : 40'(p_sel);
    ovf      = {8'b0, p_mag} >= {s_full[40:0], 7'b0};
    dbit     = (cnt >= 5'd24) ? mag[6'(cnt - 5'd24)] : 1'b0;
    rem2     = {rem, dbit};
    ge       = rem2 >= {1'b0, s_reg};
    q_fin    = {quo, ge};
    div_done = (cnt == 5'd0);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      abkf_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = s_tuser ? abkf_pkg::ST_OUT : abkf_pkg::ST_MLO;
        end
      end
      abkf_pkg::ST_MLO: state_next = abkf_pkg::ST_MHI;
      abkf_pkg::ST_MHI: state_next = abkf_pkg::ST_WB;
      abkf_pkg::ST_WB: begin
        if (op == abkf_pkg::OP_DBN) begin
          state_next = abkf_pkg::ST_DSET;
        end else if (op == abkf_pkg::OP_K0P00) begin
          state_next = abkf_pkg::ST_OUT;
        end else begin
          state_next = abkf_pkg::ST_MLO;
        end
      end
      abkf_pkg::ST_DSET: begin
        if (!s_pos || ovf) begin
          state_next = gsel ? abkf_pkg::ST_MLO : abkf_pkg::ST_DSET;
        end else begin
          state_next = abkf_pkg::ST_DIV;
        end
      end
      abkf_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = gsel ? abkf_pkg::ST_MLO : abkf_pkg::ST_DSET;
        end
      end
      abkf_pkg::ST_OUT: begin
        if (m_tready) begin
          state_next = abkf_pkg::ST_IDLE;
        end
      end
      default: state_next = abkf_pkg::ST_IDLE;
    endcase
  end

  // Handshake and multiplier control.
  always_comb begin
    s_tready        = (state == abkf_pkg::ST_IDLE);
    m_tvalid        = (state == abkf_pkg::ST_OUT);
    mac_ctl.load    = (state == abkf_pkg::ST_MLO) || (state == abkf_pkg::ST_MHI);
    mac_ctl.hi_half = (state == abkf_pkg::ST_MHI);
  end

  // Result fields.
  always_comb begin
    m_tdata[31:0]  = angle;
    m_tdata[63:32] = abkf_pkg::sat32(64'(rate) - 64'(bias));
    m_tdata[95:64] = bias;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abkf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise   <= 40'd4294967;
      bias_noise    <= 40'd12884902;
      measure_noise <= 40'd128849019;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        abkf_pkg::REG_ANGLE_NOISE:   angle_noise   <= cfg_data;
        abkf_pkg::REG_BIAS_NOISE:    bias_noise    <= cfg_data;
        abkf_pkg::REG_MEASURE_NOISE: measure_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  // Filter state and sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      c00   <= '0;
      c01   <= '0;
      c10   <= '0;
      c11   <= '0;
      k0    <= '0;
      k1    <= '0;
      op    <= abkf_pkg::OP_DRATE;
      gsel  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        abkf_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            meas <= s_tdata[31:0];
            rate <= s_tdata[63:32];
            dt   <= s_tdata[83:64];
            op   <= abkf_pkg::OP_DRATE;
            gsel <= 1'b0;
            if (s_tuser) begin
              angle <= s_tdata[31:0];
            end
          end
        end
        abkf_pkg::ST_WB: begin
          unique case (op)
            abkf_pkg::OP_DRATE: angle <= abkf_pkg::sat32(64'(angle) + sh20);
            abkf_pkg::OP_DC11: begin
              dp11 <= sh20[40:0];
              err  <= 33'(meas) - 33'(angle);
            end
            abkf_pkg::OP_DT: begin
              c00 <= abkf_pkg::sat40(64'(c00) + sh20);
              c01 <= abkf_pkg::sat40(64'(c01) - 64'(dp11));
              c10 <= abkf_pkg::sat40(64'(c10) - 64'(dp11));
            end
            abkf_pkg::OP_DBN:   c11   <= abkf_pkg::sat40(64'(c11) + sh20);
            abkf_pkg::OP_K0E:   angle <= abkf_pkg::sat32(64'(angle) + sh24);
            abkf_pkg::OP_K1E:   bias  <= abkf_pkg::sat32(64'(bias) + sh24);
            abkf_pkg::OP_K1P00: c10   <= abkf_pkg::sat40(64'(c10) - sh24);
            abkf_pkg::OP_K1P01: c11   <= abkf_pkg::sat40(64'(c11) - sh24);
            abkf_pkg::OP_K0P01: c01   <= abkf_pkg::sat40(64'(c01) - sh24);
            abkf_pkg::OP_K0P00: c00   <= abkf_pkg::sat40(64'(c00) - sh24);
            default: ;
          endcase
          if (op != abkf_pkg::OP_DBN && op != abkf_pkg::OP_K0P00) begin
            op <= abkf_pkg::op_t'(op + 4'd1);
          end
        end
        abkf_pkg::ST_DSET: begin
          s_reg <= s_full[40:0];
          mag   <= p_mag;
          neg   <= p_sel[39];
          rem   <= {8'b0, p_mag[39:7]};
          quo   <= '0;
          cnt   <= 5'd30;
          // Gain is zero or clamped without dividing.
          if (!s_pos || ovf) begin
            if (gsel) begin
              k1 <= !s_pos ? 32'sd0 : (p_sel[39] ? -{1'b0, abkf_pkg::GAIN_MAX}
                                                  : {1'b0, abkf_pkg::GAIN_MAX});
              op <= abkf_pkg::OP_K0E;
            end else begin
              k0 <= !s_pos ? 32'sd0 : (p_sel[39] ? -{1'b0, abkf_pkg::GAIN_MAX}
                                                  : {1'b0, abkf_pkg::GAIN_MAX});
            end
            gsel <= 1'b1;
          end
        end
        abkf_pkg::ST_DIV: begin
          // One restoring division step per cycle.
          rem <= ge ? 41'(rem2 - {1'b0, s_reg}) : rem2[40:0];
          quo <= q_fin[29:0];
          cnt <= cnt - 5'd1;
          if (div_done) begin
            if (gsel) begin
              k1 <= neg ? -{1'b0, q_fin} : {1'b0, q_fin};
              op <= abkf_pkg::OP_K0E;
            end else begin
              k0 <= neg ? -{1'b0, q_fin} : {1'b0, q_fin};
            end
            gsel <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Input and output sides are never open at once in this one-item design.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  // The partial remainder stays below the divisor during division.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == abkf_pkg::ST_DIV) |-> (rem < s_reg))
    else $error("division remainder out of range");

  // A finished division leaves a gain inside the clamp range.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == abkf_pkg::ST_DIV && div_done) |=>
      (k0 != 32'sh80000000 && k1 != 32'sh80000000))
    else $error("gain outside clamp range");
`endif

endmodule

@@ test/tb_angle_bias_kalman_filter.sv @@
// Self-checking testbench for angle_bias_kalman_filter: drives sample items and checks results.
// A scoreboard class predicts every result and compares it; needs abkf_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_angle_bias_kalman_filter;

  // Index that names no register; a write to it must change nothing.
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_SEED   = 1'b1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [39:0] NOISE_MAX = 40'hffffffffff;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;  // measured_angle[31:0], gyro_rate[63:32], step_time[83:64]
  logic        s_tuser = 1'b0;  // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;  // filtered_angle[31:0], corrected_rate[63:32], bias_estimate[95:64]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [39:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int cycles = 0;

  angle_bias_kalman_filter u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Fixed-point filter predictor and the queue of results it expects.
  class kalman_scoreboard;
    longint unsigned angle_noise, bias_noise, measure_noise;
    longint angle_est, bias_est, cov00, cov01, cov10, cov11;
    logic [95:0] expected_results[$];
    int errors;

    function new();
      angle_noise = 64'd4294967;
      bias_noise = 64'd12884902;
      measure_noise = 64'd128849019;
      angle_est = 0; bias_est = 0;
      cov00 = 0; cov01 = 0; cov10 = 0; cov11 = 0;
      errors = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clip40(longint v);
      if (v > 64'sd549755813887) return 64'sd549755813887;
      if (v < -64'sd549755813888) return -64'sd549755813888;
      return v;
    endfunction

    // floor(k * p / 2^24), split so that no partial product overflows.
    function longint scale_q24(longint k, longint p);
      longint hi, lo;
      hi = p >>> 16;
      lo = p - hi * 65536;
      return (k * hi + ((k * lo) >>> 16)) >>> 8;
    endfunction

    // Signed Q.24 gain p / s with its magnitude clamped.
    function longint gain_q24(longint p, longint s);
      longint unsigned mag, q;
      mag = (p < 0) ? longint'(-p) : p;
      q = (mag << 24) / longint'(s);
      if (q > 64'd2147483647) q = 64'd2147483647;
      return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void set_reg(logic [1:0] idx, logic [39:0] v);
      case (idx)
        abkf_pkg::REG_ANGLE_NOISE: angle_noise = 64'(v);
        abkf_pkg::REG_BIAS_NOISE: bias_noise = 64'(v);
        abkf_pkg::REG_MEASURE_NOISE: measure_noise = 64'(v);
        default: ;
      endcase
    endfunction

    // Runs one filter step, or for a seed item sets the angle, on an accepted sample and queues its result.
    function void note_sample(logic mode, logic [31:0] ma, logic [31:0] gr, logic [19:0] st);
      longint meas, rate, dt, dp11, t, s, k0, k1, err, p00, p01;
      logic [31:0] a, r, b;
      meas = longint'($signed(ma));
      rate = longint'($signed(gr));
      dt = longint'(st);
      if (mode == MODE_SEED) begin
        angle_est = meas;
      end else begin
        angle_est = clip32(angle_est + ((dt * (rate - bias_est)) >>> 20));
        dp11 = (dt * cov11) >>> 20;
        t = dp11 - cov01 - cov10 + longint'(angle_noise);
        cov00 = clip40(cov00 + ((dt * t) >>> 20));
        cov01 = clip40(cov01 - dp11);
        cov10 = clip40(cov10 - dp11);
        cov11 = clip40(cov11 + ((dt * longint'(bias_noise)) >>> 20));
        s = cov00 + longint'(measure_noise);
        // A non-positive innovation variance leaves the prediction untouched.
        if (s > 0) begin
          k0 = gain_q24(cov00, s);
          k1 = gain_q24(cov10, s);
        end else begin
          k0 = 0;
          k1 = 0;
        end
        err = meas - angle_est;
        angle_est = clip32(angle_est + scale_q24(k0, err));
        bias_est = clip32(bias_est + scale_q24(k1, err));
        p00 = cov00;
        p01 = cov01;
        cov00 = clip40(cov00 - scale_q24(k0, p00));
        cov01 = clip40(cov01 - scale_q24(k0, p01));
        cov10 = clip40(cov10 - scale_q24(k1, p00));
        cov11 = clip40(cov11 - scale_q24(k1, p01));
      end
      a = angle_est[31:0];
      r = 32'(clip32(rate - bias_est));
      b = bias_est[31:0];
      expected_results.push_back({b, r, a});
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task check_result(logic [95:0] got);
      logic [95:0] want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result item %h", got));
        return;
      end
      want = expected_results.pop_front();
      if (got[31:0] !== want[31:0])
        report($sformatf("filtered_angle %h, expected %h", got[31:0], want[31:0]));
      if (got[63:32] !== want[63:32])
        report($sformatf("corrected_rate %h, expected %h", got[63:32], want[63:32]));
      if (got[95:64] !== want[95:64])
        report($sformatf("bias_estimate %h, expected %h", got[95:64], want[95:64]));
    endtask
  endclass

  kalman_scoreboard sb = new();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watch both handshakes on the values present before the edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_sample(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[83:64]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, and on request one long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task send_sample(logic mode, logic [31:0] ma, logic [31:0] gr, logic [19:0] st);
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, st, gr, ma};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task sender_gap(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Pause the sender until every expected result has come, plus some settling.
  task drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [39:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 1'b0;
  endtask

  // Mostly plausible sensor data; some items use the whole field range.
  task send_random();
    logic mode;
    logic [31:0] ma, gr;
    logic [19:0] st;
    mode = ($urandom_range(99) < 6) ? MODE_SEED : MODE_UPDATE;
    if ($urandom_range(99) < 15) begin
      ma = $urandom;
      gr = $urandom;
      st = 20'($urandom);
    end else begin
      ma = $urandom_range(180 << 16) - (90 << 16);
      gr = $urandom_range(500 << 16) - (250 << 16);
      st = 20'($urandom_range(200, 20000));
    end
    send_sample(mode, ma, gr, st);
    if ($urandom_range(99) < send_idle_pct) sender_gap($urandom_range(1, 8));
  endtask

  initial begin
    logic [39:0] cfg_pick[3];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, seed mode, and a zero measurement noise.
    send_sample(MODE_UPDATE, 32'h0, 32'h0, 20'h0);
    send_sample(MODE_UPDATE, 32'h7fffffff, 32'h7fffffff, 20'hfffff);
    send_sample(MODE_UPDATE, 32'h80000000, 32'h80000000, 20'hfffff);
    send_sample(MODE_SEED, 32'h7fffffff, 32'h80000000, 20'h0);
    send_sample(MODE_UPDATE, 32'h80000000, 32'h7fffffff, 20'h00001);
    send_sample(MODE_SEED, 32'h80000000, 32'h7fffffff, 20'hfffff);
    send_sample(MODE_UPDATE, 32'h00010000, 32'hffff0000, 20'h00418);
    drain();
    write_reg(abkf_pkg::REG_MEASURE_NOISE, 40'h0);
    write_reg(REG_NONE, NOISE_MAX);
    send_sample(MODE_UPDATE, 32'h00100000, 32'h00020000, 20'h0);
    send_sample(MODE_UPDATE, 32'hfff00000, 32'h00020000, 20'h00100);
    drain();
    write_reg(abkf_pkg::REG_ANGLE_NOISE, NOISE_MAX);
    write_reg(abkf_pkg::REG_BIAS_NOISE, NOISE_MAX);
    write_reg(abkf_pkg::REG_MEASURE_NOISE, 40'h1);
    for (int i = 0; i < 6; i++)
      send_sample(MODE_UPDATE, i[0] ? 32'h7fffffff : 32'h80000000, 32'h12345678, 20'hfffff);
    drain();
    write_reg(abkf_pkg::REG_ANGLE_NOISE, 40'h0);
    write_reg(abkf_pkg::REG_BIAS_NOISE, 40'h0);
    write_reg(abkf_pkg::REG_MEASURE_NOISE, NOISE_MAX);
    send_sample(MODE_UPDATE, 32'h00050000, 32'h00010000, 20'h00418);
    send_sample(MODE_SEED, 32'h00000000, 32'h00010000, 20'h00418);
    drain();

    // Random phases over idling patterns and register settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 56; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case (phase)
        0: begin
          cfg_pick[0] = 40'd4294967;
          cfg_pick[1] = 40'd12884902;
          cfg_pick[2] = 40'd128849019;
        end
        1: begin cfg_pick[0] = NOISE_MAX; cfg_pick[1] = NOISE_MAX; cfg_pick[2] = NOISE_MAX; end
        2: begin cfg_pick[0] = 40'd0; cfg_pick[1] = 40'd0; cfg_pick[2] = 40'd1; end
        default: begin
          for (int k = 0; k < 3; k++)
            cfg_pick[k] = 40'({8'($urandom_range(255)), 32'($urandom)} >> $urandom_range(39));
          if (cfg_pick[2] == 40'd0) cfg_pick[2] = 40'd1;
        end
      endcase
      drain();
      write_reg(abkf_pkg::REG_ANGLE_NOISE, cfg_pick[0]);
      write_reg(abkf_pkg::REG_BIAS_NOISE, cfg_pick[1]);
      write_reg(abkf_pkg::REG_MEASURE_NOISE, cfg_pick[2]);
      // Long receiver hold-off while items keep being offered.
      if (phase == 2) hold_req = 1'b1;
      for (int i = 0; i < 210; i++) send_random();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/abkf_pkg.sv
rtl/abkf_mac.sv
rtl/angle_bias_kalman_filter.sv
test/tb_angle_bias_kalman_filter.sv
